// ----- sv/vtp_pkg.sv -----
// ---------------------------------------------------------------------------
// vtp_pkg
// Shared types and constants for the vertex transform and projection core.
// ---------------------------------------------------------------------------
package vtp_pkg;

  // Default arithmetic format: signed words with a binary point.
  localparam int FRAC_BITS_DEF  = 16;
  localparam int WORD_WIDTH_DEF = 32;

  // Fixed field widths of the channels.
  localparam int COEF_W = 32;
  localparam int VERT_W = 32;
  localparam int SCR_W  = 16;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // Configuration port.
  localparam int                 ADDR_W          = 2;
  localparam logic [ADDR_W-1:0]  REG_FOCAL_ADDR  = 2'd0;
  localparam logic [31:0]        FOCAL_RESET     = 32'h0001_0000;

  // Matrix selects. The last select names no matrix, so writes to it are dropped.
  localparam logic [1:0] MSEL_MODEL  = 2'd0;
  localparam logic [1:0] MSEL_CAMERA = 2'd1;
  localparam logic [1:0] MSEL_VIEW   = 2'd2;
  localparam logic [1:0] MSEL_UNUSED = 2'd3;

  // Commands.
  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_XFORM = 1'b1
  } cmd_t;

  // Control word that travels with every item through the back.
  typedef struct packed {
    cmd_t        cmd;
    logic [1:0]  sel;
    logic [3:0]  idx;
    logic [31:0] coef;
    logic        sat;
    logic        fault;
  } ctl_t;

  // One queued word.
  typedef struct packed {
    ctl_t               ctl;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } item_t;

  // Per-lane special cases of the perspective divide.
  typedef struct packed {
    logic zero_den;
    logic zero_num;
    logic neg;
    logic over;
  } lane_flags_t;

endpackage

// ----- sv/vtp_in_if.sv -----
// ---------------------------------------------------------------------------
// vtp_in_if
// Input channel: one command word per handshake.
// ---------------------------------------------------------------------------
interface vtp_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic [1:0]         matrix_select;
  logic [3:0]         element_index;
  logic signed [31:0] element_value;
  logic signed [31:0] vertex_x;
  logic signed [31:0] vertex_y;
  logic signed [31:0] vertex_z;

  modport source (output valid, command, matrix_select, element_index, element_value,
                  vertex_x, vertex_y, vertex_z, input ready);
  modport sink   (input valid, command, matrix_select, element_index, element_value,
                  vertex_x, vertex_y, vertex_z, output ready);
endinterface

// ----- sv/vtp_out_if.sv -----
// ---------------------------------------------------------------------------
// vtp_out_if
// Result channel: one projected vertex per handshake.
// ---------------------------------------------------------------------------
interface vtp_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] screen_x;
  logic signed [15:0] screen_y;
  logic signed [15:0] depth;
  logic               divide_fault;
  logic               saturated;

  modport source (output valid, screen_x, screen_y, depth, divide_fault, saturated,
                  input ready);
  modport sink   (input valid, screen_x, screen_y, depth, divide_fault, saturated,
                  output ready);
endinterface

// ----- sv/vtp_queue.sv -----
// ---------------------------------------------------------------------------
// vtp_queue
// Short FIFO that decouples the accepting front from the transform back.
// ---------------------------------------------------------------------------
module vtp_queue #(
  parameter int DEPTH = vtp_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  vtp_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output vtp_pkg::item_t pop_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  vtp_pkg::item_t    mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  count_r;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_item = mem_r[rd_ptr_r];

  // Storage is written only on a push.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // The fill count stays within the depth.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH)) else $error("queue count out of range");

  // No word is pushed into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("queue overflow");

  // No word is popped from an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("queue underflow");

endmodule

// ----- sv/vtp_vecmat.sv -----
// ---------------------------------------------------------------------------
// vtp_vecmat
// Row vector times 4x4 matrix: a product stage and a sum-and-clamp stage.
// The matrix lives here and is updated when a write word passes by.
// ---------------------------------------------------------------------------
module vtp_vecmat #(
  parameter int         WORD_WIDTH = vtp_pkg::WORD_WIDTH_DEF,
  parameter int         FRAC_BITS  = vtp_pkg::FRAC_BITS_DEF,
  parameter int         IN_W       = vtp_pkg::VERT_W,
  parameter logic [1:0] MSEL       = vtp_pkg::MSEL_MODEL
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic                         in_valid,
  input  vtp_pkg::ctl_t                in_ctl,
  input  logic signed [IN_W-1:0]       in_vec  [4],
  output logic                         out_valid,
  output vtp_pkg::ctl_t                out_ctl,
  output logic signed [WORD_WIDTH-1:0] out_vec [4]
);

  localparam int CW = vtp_pkg::COEF_W;
  localparam int PW = IN_W + CW;
  localparam int SW = PW + 2;
  localparam int W  = WORD_WIDTH;
  localparam logic signed [SW-1:0] MAXW = {{(SW - W + 1){1'b0}}, {(W - 1){1'b1}}};
  localparam logic signed [SW-1:0] MINW = {{(SW - W + 1){1'b1}}, {(W - 1){1'b0}}};

  logic signed [CW-1:0]  mat_r  [16];
  logic                  p_valid_r;
  vtp_pkg::ctl_t         p_ctl_r;
  logic signed [PW-1:0]  prod_r [4][4];
  logic                  s_valid_r;
  vtp_pkg::ctl_t         s_ctl_r;
  vtp_pkg::ctl_t         s_ctl_nxt;
  logic signed [W-1:0]   s_vec_r [4];
  logic signed [SW-1:0]  sum    [4];
  logic signed [W-1:0]   vec_nxt [4];
  logic [3:0]            clamp;

  // Product truncated toward zero to the fraction width.
  function automatic logic signed [PW-1:0] trunc_prod(input logic signed [IN_W-1:0] a,
                                                      input logic signed [CW-1:0] c);
    logic signed [PW-1:0] p;
    logic signed [PW-1:0] bias;
    p    = PW'(a) * PW'(c);
    bias = p[PW-1] ? PW'((64'd1 << FRAC_BITS) - 64'd1) : '0;
    return (p + bias) >>> FRAC_BITS;
  endfunction

  // Matrix coefficients, cleared at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) begin
        mat_r[i] <= '0;
      end
    end else if (adv && in_valid && in_ctl.cmd == vtp_pkg::CMD_WRITE && in_ctl.sel == MSEL) begin
      mat_r[in_ctl.idx] <= in_ctl.coef;
    end
  end

  // Product stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (adv) begin
      p_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_ctl_r <= in_ctl;
      for (int j = 0; j < 4; j++) begin
        for (int k = 0; k < 4; k++) begin
          prod_r[j][k] <= trunc_prod(in_vec[k], mat_r[k * 4 + j]);
        end
      end
    end
  end

  // Column sums clamped to a word.
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      sum[j] = SW'(prod_r[j][0]) + SW'(prod_r[j][1]) + SW'(prod_r[j][2]) + SW'(prod_r[j][3]);
      clamp[j] = 1'b0;
      if (sum[j] > MAXW) begin
        vec_nxt[j] = MAXW[W-1:0];
        clamp[j]   = 1'b1;
      end else if (sum[j] < MINW) begin
        vec_nxt[j] = MINW[W-1:0];
        clamp[j]   = 1'b1;
      end else begin
        vec_nxt[j] = sum[j][W-1:0];
      end
    end
  end

  // A clamp on a transform word marks it saturated.
  always_comb begin
    s_ctl_nxt     = p_ctl_r;
    s_ctl_nxt.sat = p_ctl_r.sat | (p_ctl_r.cmd == vtp_pkg::CMD_XFORM && (|clamp));
  end

  // Sum stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (adv) begin
      s_valid_r <= p_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s_ctl_r <= s_ctl_nxt;
      s_vec_r <= vec_nxt;
    end
  end

  assign out_valid = s_valid_r;
  assign out_ctl   = s_ctl_r;
  assign out_vec   = s_vec_r;

endmodule

// ----- sv/vtp_divide.sv -----
// ---------------------------------------------------------------------------
// vtp_divide
// Perspective step: divisor product, then three pipelined restoring
// dividers that retire one quotient bit per stage.
// ---------------------------------------------------------------------------
module vtp_divide #(
  parameter int WORD_WIDTH = vtp_pkg::WORD_WIDTH_DEF,
  parameter int FRAC_BITS  = vtp_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic signed [31:0]           focal,
  input  logic                         in_valid,
  input  vtp_pkg::ctl_t                in_ctl,
  input  logic signed [WORD_WIDTH-1:0] in_b  [4],
  output logic                         out_valid,
  output vtp_pkg::ctl_t                out_ctl,
  output logic signed [WORD_WIDTH-1:0] out_p [3]
);

  localparam int W  = WORD_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int PW = W + 33;
  localparam logic signed [PW-1:0] MAXP = {{(PW - W + 1){1'b0}}, {(W - 1){1'b1}}};
  localparam logic signed [PW-1:0] MINP = {{(PW - W + 1){1'b1}}, {(W - 1){1'b0}}};
  localparam logic signed [W-1:0]  MAXW = {1'b0, {(W - 1){1'b1}}};
  localparam logic signed [W-1:0]  MINW = {1'b1, {(W - 1){1'b0}}};

  // Divisor product stage.
  logic                 d1_valid_r;
  vtp_pkg::ctl_t        d1_ctl_r;
  logic signed [PW-1:0] d1_tp_r;
  logic signed [W-1:0]  d1_b_r [4];
  logic signed [32:0]   neg_f;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] bias;

  // Divisor clamp stage.
  logic                 d2_valid_r;
  vtp_pkg::ctl_t        d2_ctl_r;
  vtp_pkg::ctl_t        d2_ctl_nxt;
  logic signed [W-1:0]  d2_d_r;
  logic signed [W-1:0]  d2_b_r [4];

  // Divider stages: index 0 is the setup, index W holds the last quotient bit.
  logic                  st_valid_r [W+1];
  vtp_pkg::ctl_t         st_ctl_r   [W+1];
  logic [W-1:0]          st_rem_r   [W+1][3];
  logic [W-1:0]          st_num_r   [W+1][3];
  logic [W-1:0]          st_q_r     [W+1][3];
  logic [W-1:0]          st_dm_r    [W+1][3];
  vtp_pkg::lane_flags_t  st_fl_r    [W+1][3];

  logic signed [W-1:0]   ln_n [3];
  logic signed [W-1:0]   ln_d [3];
  logic [W-1:0]          ln_nm [3];
  logic [W-1:0]          ln_dm [3];
  logic [W:0]            step_t [W+1][3];
  logic                  step_ge [W+1][3];

  // Result stage.
  logic                 q_valid_r;
  vtp_pkg::ctl_t        q_ctl_r;
  vtp_pkg::ctl_t        q_ctl_nxt;
  logic signed [W-1:0]  q_p_r [3];
  logic signed [W-1:0]  p_nxt [3];
  logic [2:0]           lane_fault;
  logic [2:0]           lane_sat;
  logic [W-1:0]         qf;

  // Divisor -f*b2, truncated toward zero.
  always_comb begin
    neg_f = -{focal[31], focal};
    prod  = PW'(neg_f) * PW'(in_b[2]);
    bias  = prod[PW-1] ? PW'((64'd1 << F) - 64'd1) : '0;
  end

  // A clamped divisor marks a transform word saturated.
  always_comb begin
    d2_ctl_nxt = d1_ctl_r;
    if (d1_ctl_r.cmd == vtp_pkg::CMD_XFORM && (d1_tp_r > MAXP || d1_tp_r < MINP)) begin
      d2_ctl_nxt.sat = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_valid_r <= 1'b0;
      d2_valid_r <= 1'b0;
    end else if (adv) begin
      d1_valid_r <= in_valid;
      d2_valid_r <= d1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d1_ctl_r <= in_ctl;
      d1_tp_r  <= (prod + bias) >>> F;
      d1_b_r   <= in_b;
      d2_ctl_r <= d2_ctl_nxt;
      d2_b_r   <= d1_b_r;
      if (d1_tp_r > MAXP) begin
        d2_d_r <= MAXW;
      end else if (d1_tp_r < MINP) begin
        d2_d_r <= MINW;
      end else begin
        d2_d_r <= d1_tp_r[W-1:0];
      end
    end
  end

  // Lane operands and magnitudes for the setup stage.
  always_comb begin
    ln_n[0] = d2_b_r[0];
    ln_n[1] = d2_b_r[1];
    ln_n[2] = d2_b_r[2];
    ln_d[0] = d2_d_r;
    ln_d[1] = d2_d_r;
    ln_d[2] = d2_b_r[3];
    for (int l = 0; l < 3; l++) begin
      ln_nm[l] = ln_n[l][W-1] ? W'(-ln_n[l]) : W'(ln_n[l]);
      ln_dm[l] = ln_d[l][W-1] ? W'(-ln_d[l]) : W'(ln_d[l]);
    end
  end

  // One restoring step per stage: compare and subtract.
  always_comb begin
    for (int s = 0; s <= W; s++) begin
      for (int l = 0; l < 3; l++) begin
        step_t[s][l]  = {st_rem_r[s][l], st_num_r[s][l][W-1]};
        step_ge[s][l] = step_t[s][l] >= {1'b0, st_dm_r[s][l]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= W; s++) begin
        st_valid_r[s] <= 1'b0;
      end
    end else if (adv) begin
      st_valid_r[0] <= d2_valid_r;
      for (int s = 1; s <= W; s++) begin
        st_valid_r[s] <= st_valid_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // Setup: detect zero divisors and quotients of a word or more.
      st_ctl_r[0] <= d2_ctl_r;
      for (int l = 0; l < 3; l++) begin
        st_rem_r[0][l]          <= W'(ln_nm[l] >> (W - F));
        st_num_r[0][l]          <= ln_nm[l] << F;
        st_q_r[0][l]            <= '0;
        st_dm_r[0][l]           <= ln_dm[l];
        st_fl_r[0][l].zero_den  <= (ln_d[l] == '0);
        st_fl_r[0][l].zero_num  <= (ln_n[l] == '0);
        st_fl_r[0][l].neg       <= ln_n[l][W-1] ^ ln_d[l][W-1];
        st_fl_r[0][l].over      <= (2*W)'({ln_nm[l], {F{1'b0}}}) >= {ln_dm[l], {W{1'b0}}};
      end
      for (int s = 1; s <= W; s++) begin
        st_ctl_r[s] <= st_ctl_r[s-1];
        for (int l = 0; l < 3; l++) begin
          st_rem_r[s][l] <= step_ge[s-1][l]
                            ? W'(step_t[s-1][l] - {1'b0, st_dm_r[s-1][l]})
                            : W'(step_t[s-1][l]);
          st_num_r[s][l] <= st_num_r[s-1][l] << 1;
          st_q_r[s][l]   <= {st_q_r[s-1][l][W-2:0], step_ge[s-1][l]};
          st_dm_r[s][l]  <= st_dm_r[s-1][l];
          st_fl_r[s][l]  <= st_fl_r[s-1][l];
        end
      end
    end
  end

  // Signed quotient, clamped, with the zero-divisor rule.
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      qf            = st_q_r[W][l];
      lane_fault[l] = 1'b0;
      lane_sat[l]   = 1'b0;
      if (st_fl_r[W][l].zero_den) begin
        lane_fault[l] = 1'b1;
        if (st_fl_r[W][l].zero_num) begin
          p_nxt[l] = '0;
        end else begin
          p_nxt[l] = st_fl_r[W][l].neg ? MINW : MAXW;
        end
      end else if (st_fl_r[W][l].over ||
                   (st_fl_r[W][l].neg ? (qf[W-1] && (|qf[W-2:0])) : qf[W-1])) begin
        lane_sat[l] = 1'b1;
        p_nxt[l]    = st_fl_r[W][l].neg ? MINW : MAXW;
      end else begin
        p_nxt[l]    = st_fl_r[W][l].neg ? W'(-qf) : W'(qf);
      end
    end
  end

  // Lane flags of a transform word fold into its control word.
  always_comb begin
    q_ctl_nxt       = st_ctl_r[W];
    q_ctl_nxt.sat   = st_ctl_r[W].sat |
                      (st_ctl_r[W].cmd == vtp_pkg::CMD_XFORM && (|lane_sat));
    q_ctl_nxt.fault = st_ctl_r[W].fault |
                      (st_ctl_r[W].cmd == vtp_pkg::CMD_XFORM && (|lane_fault));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_valid_r <= 1'b0;
    end else if (adv) begin
      q_valid_r <= st_valid_r[W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q_ctl_r <= q_ctl_nxt;
      q_p_r   <= p_nxt;
    end
  end

  assign out_valid = q_valid_r;
  assign out_ctl   = q_ctl_r;
  assign out_p     = q_p_r;

endmodule

// ----- sv/vertex_transform_project_core.sv -----
// Path from an accepted word to its result: queue, model and camera product and
// sum stages, perspective divide, view product and sum stages, output register.
// Throughput: one word per cycle while the output is not stalled; the divide is a
// pipeline with one quotient bit per stage, so every stage takes a new word each cycle it advances.
// Reset (synchronous, rst_n low): all matrix coefficients clear to zero,
// focal_length returns to 1.0, and the queue and pipeline empty.
// ---------------------------------------------------------------------------
// vertex_transform_project_core
// Fixed-point model/camera transform, perspective divide and view-clip
// transform. Writes travel down the pipeline and update each matrix at the
// stage that reads it, so every vertex sees the matrices in command order.
// ---------------------------------------------------------------------------
module vertex_transform_project_core #(
  parameter int FRAC_BITS  = vtp_pkg::FRAC_BITS_DEF,
  parameter int WORD_WIDTH = vtp_pkg::WORD_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  vtp_in_if.sink                     in_ch,
  vtp_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [vtp_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int W  = WORD_WIDTH;
  localparam int VW = W + 1;
  localparam logic signed [W-1:0] MAXO = W'(32767);
  localparam logic signed [W-1:0] MINO = -W'(32768);

  logic [31:0]          focal_r;
  logic                 cfg_wr;
  logic                 adv;
  logic                 q_full, q_empty, q_push, q_pop;
  vtp_pkg::item_t       in_item, q_item;

  logic signed [31:0]   m_in [4];
  logic                 m_valid;
  vtp_pkg::ctl_t        m_ctl;
  logic signed [W-1:0]  m_vec [4];
  logic                 c_valid;
  vtp_pkg::ctl_t        c_ctl;
  logic signed [W-1:0]  c_vec [4];
  logic                 d_valid;
  vtp_pkg::ctl_t        d_ctl;
  logic signed [W-1:0]  d_p [3];
  logic signed [VW-1:0] v_in [4];
  logic                 v_valid;
  vtp_pkg::ctl_t        v_ctl;
  logic signed [W-1:0]  v_vec [4];

  logic signed [W-1:0]  trunc_v [3];
  logic [15:0]          scr_nxt [3];
  logic [2:0]           out_clamp;

  logic                 out_valid_r;
  logic [15:0]          screen_x_r, screen_y_r, depth_r;
  logic                 fault_r, sat_r;

  // Configuration register.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == vtp_pkg::REG_FOCAL_ADDR);
  assign prdata = (paddr == vtp_pkg::REG_FOCAL_ADDR) ? focal_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_r <= vtp_pkg::FOCAL_RESET;
    end else if (cfg_wr) begin
      focal_r <= pwdata;
    end
  end

  // Front: classify the word and queue it.
  always_comb begin
    in_item.ctl.cmd   = vtp_pkg::cmd_t'(in_ch.command);
    in_item.ctl.sel   = in_ch.matrix_select;
    in_item.ctl.idx   = in_ch.element_index;
    in_item.ctl.coef  = in_ch.element_value;
    in_item.ctl.sat   = 1'b0;
    in_item.ctl.fault = 1'b0;
    in_item.x         = in_ch.vertex_x;
    in_item.y         = in_ch.vertex_y;
    in_item.z         = in_ch.vertex_z;
  end

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;
  assign adv         = !out_valid_r || out_ch.ready;
  assign q_pop       = adv && !q_empty;

  vtp_queue #(
    .DEPTH (vtp_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (in_item),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_item  (q_item)
  );

  // Back: model stage on (x, y, z, 1).
  always_comb begin
    m_in[0] = q_item.x;
    m_in[1] = q_item.y;
    m_in[2] = q_item.z;
    m_in[3] = 32'(64'd1 << FRAC_BITS);
  end

  vtp_vecmat #(
    .WORD_WIDTH (W),
    .FRAC_BITS  (FRAC_BITS),
    .IN_W       (vtp_pkg::VERT_W),
    .MSEL       (vtp_pkg::MSEL_MODEL)
  ) u_model (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (q_pop),
    .in_ctl    (q_item.ctl),
    .in_vec    (m_in),
    .out_valid (m_valid),
    .out_ctl   (m_ctl),
    .out_vec   (m_vec)
  );

  vtp_vecmat #(
    .WORD_WIDTH (W),
    .FRAC_BITS  (FRAC_BITS),
    .IN_W       (W),
    .MSEL       (vtp_pkg::MSEL_CAMERA)
  ) u_camera (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (m_valid),
    .in_ctl    (m_ctl),
    .in_vec    (m_vec),
    .out_valid (c_valid),
    .out_ctl   (c_ctl),
    .out_vec   (c_vec)
  );

  vtp_divide #(
    .WORD_WIDTH (W),
    .FRAC_BITS  (FRAC_BITS)
  ) u_divide (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .focal     (focal_r),
    .in_valid  (c_valid),
    .in_ctl    (c_ctl),
    .in_b      (c_vec),
    .out_valid (d_valid),
    .out_ctl   (d_ctl),
    .out_p     (d_p)
  );

  // View-clip stage on (p0, p1, p2, 1).
  always_comb begin
    v_in[0] = VW'(d_p[0]);
    v_in[1] = VW'(d_p[1]);
    v_in[2] = VW'(d_p[2]);
    v_in[3] = VW'(64'd1 << FRAC_BITS);
  end

  vtp_vecmat #(
    .WORD_WIDTH (W),
    .FRAC_BITS  (FRAC_BITS),
    .IN_W       (VW),
    .MSEL       (vtp_pkg::MSEL_VIEW)
  ) u_view (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (d_valid),
    .in_ctl    (d_ctl),
    .in_vec    (v_in),
    .out_valid (v_valid),
    .out_ctl   (v_ctl),
    .out_vec   (v_vec)
  );

  // Truncate toward zero to integers and clamp to 16 bits.
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      trunc_v[l]   = $signed(v_vec[l] +
                             (v_vec[l][W-1] ? W'((64'd1 << FRAC_BITS) - 64'd1) : '0))
                     >>> FRAC_BITS;
      out_clamp[l] = 1'b0;
      if (trunc_v[l] > MAXO) begin
        scr_nxt[l]   = 16'h7FFF;
        out_clamp[l] = 1'b1;
      end else if (trunc_v[l] < MINO) begin
        scr_nxt[l]   = 16'h8000;
        out_clamp[l] = 1'b1;
      end else begin
        scr_nxt[l]   = trunc_v[l][15:0];
      end
    end
  end

  // Output register; write words end here without a result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v_valid && (v_ctl.cmd == vtp_pkg::CMD_XFORM);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      screen_x_r <= scr_nxt[0];
      screen_y_r <= scr_nxt[1];
      depth_r    <= scr_nxt[2];
      fault_r    <= v_ctl.fault;
      sat_r      <= v_ctl.sat | (|out_clamp);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.screen_x     = screen_x_r;
  assign out_ch.screen_y     = screen_y_r;
  assign out_ch.depth        = depth_r;
  assign out_ch.divide_fault = fault_r;
  assign out_ch.saturated    = sat_r;

  // A write word leaving the pipeline never shows up as a result.
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && v_valid && v_ctl.cmd == vtp_pkg::CMD_WRITE) |=> !out_valid_r)
    else $error("write word produced a result");

  // A focal length write lands in the register.
  a_focal_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> (focal_r == $past(pwdata)))
    else $error("focal length write lost");

endmodule

// ----- tb/tb_vertex_transform_project_core.sv -----
// ---------------------------------------------------------------------------
// tb_vertex_transform_project_core
// Self-checking bench for the vertex transform and projection core. It loads
// matrix coefficients and sends vertices with random gaps on both channels.
// The focal length is changed between phases. A scoreboard predicts every
// projected vertex in fixed point and compares each result field with it.
// ---------------------------------------------------------------------------
module tb_vertex_transform_project_core;

  localparam int FB = vtp_pkg::FRAC_BITS_DEF;
  localparam int DRAIN_CYCLES = vtp_pkg::WORD_WIDTH_DEF + 30;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic signed [15:0] dep;
    logic               fault;
    logic               sat;
  } projection_t;

  // Scoreboard: mirrors the matrices and the focal length, and holds the
  // projections still to arrive.
  class projection_scoreboard;
    logic signed [31:0] coef [48];
    logic signed [31:0] focal;
    projection_t        pending [$];
    int                 errors;
    bit                 sat_seen;
    bit                 fault_seen;

    function void clear();
      foreach (coef[i]) coef[i] = '0;
      focal = vtp_pkg::FOCAL_RESET;
      pending.delete();
      errors = 0;
    endfunction

    // Exact product, truncated toward zero to the fraction width.
    function wide_t trunc_mul(wide_t a, wide_t b);
      wide_t p;
      p = a * b;
      if (p < 0) return -((-p) >>> FB);
      return p >>> FB;
    endfunction

    function wide_t clamp_word(wide_t v);
      wide_t hi, lo;
      hi = (wide_t'(1) <<< (vtp_pkg::WORD_WIDTH_DEF - 1)) - 1;
      lo = -(wide_t'(1) <<< (vtp_pkg::WORD_WIDTH_DEF - 1));
      if (v > hi) begin
        sat_seen = 1;
        return hi;
      end
      if (v < lo) begin
        sat_seen = 1;
        return lo;
      end
      return v;
    endfunction

    // Row vector times one 4x4 matrix of the store.
    function void row_times_matrix(input wide_t vin [4], input int base,
                                   output wide_t vout [4]);
      wide_t acc;
      for (int j = 0; j < 4; j++) begin
        acc = 0;
        for (int k = 0; k < 4; k++) acc += trunc_mul(vin[k], coef[base + k*4 + j]);
        vout[j] = clamp_word(acc);
      end
    endfunction

    // Quotient with the zero-divisor rule: it flags a fault and clamps
    // by the sign of the numerator without setting saturation.
    function wide_t fixed_div(wide_t n, wide_t d);
      if (d == 0) begin
        fault_seen = 1;
        if (n == 0) return 0;
        if (n > 0) return (wide_t'(1) <<< (vtp_pkg::WORD_WIDTH_DEF - 1)) - 1;
        return -(wide_t'(1) <<< (vtp_pkg::WORD_WIDTH_DEF - 1));
      end
      return clamp_word((n <<< FB) / d);
    endfunction

    function logic signed [15:0] to_screen(wide_t v);
      wide_t mg, lim, r;
      mg  = (v < 0 ? -v : v) >>> FB;
      lim = v < 0 ? 32768 : 32767;
      if (mg > lim) begin
        sat_seen = 1;
        mg = lim;
      end
      r = v < 0 ? -mg : mg;
      return r[15:0];
    endfunction

    // Note one accepted input word.
    function void note_word(vtp_pkg::cmd_t cmd, logic [1:0] sel, logic [3:0] idx,
                            logic signed [31:0] val, logic signed [31:0] x,
                            logic signed [31:0] y, logic signed [31:0] z);
      wide_t v [4], a [4], b [4], p [4], r [4];
      wide_t d;
      projection_t e;
      if (cmd == vtp_pkg::CMD_WRITE) begin
        if (sel != vtp_pkg::MSEL_UNUSED) coef[sel*16 + idx] = val;
        return;
      end
      sat_seen = 0;
      fault_seen = 0;
      v[0] = x;
      v[1] = y;
      v[2] = z;
      v[3] = wide_t'(1) <<< FB;
      row_times_matrix(v, vtp_pkg::MSEL_MODEL * 16, a);
      row_times_matrix(a, vtp_pkg::MSEL_CAMERA * 16, b);
      d = clamp_word(trunc_mul(-wide_t'(focal), b[2]));
      p[0] = fixed_div(b[0], d);
      p[1] = fixed_div(b[1], d);
      p[2] = fixed_div(b[2], b[3]);
      p[3] = wide_t'(1) <<< FB;
      row_times_matrix(p, vtp_pkg::MSEL_VIEW * 16, r);
      e.sx = to_screen(r[0]);
      e.sy = to_screen(r[1]);
      e.dep = to_screen(r[2]);
      e.fault = fault_seen;
      e.sat = sat_seen;
      pending.push_back(e);
    endfunction

    // Compare one accepted result with the oldest prediction.
    function void check_result(logic signed [15:0] sx, logic signed [15:0] sy,
                               logic signed [15:0] dep, logic fault, logic sat);
      projection_t e;
      if (pending.size() == 0) begin
        $error("unexpected result word: screen_x %0d screen_y %0d depth %0d", sx, sy, dep);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (sx !== e.sx) begin
        $error("screen_x: expected %0d, got %0d", e.sx, sx);
        errors++;
      end
      if (sy !== e.sy) begin
        $error("screen_y: expected %0d, got %0d", e.sy, sy);
        errors++;
      end
      if (dep !== e.dep) begin
        $error("depth: expected %0d, got %0d", e.dep, dep);
        errors++;
      end
      if (fault !== e.fault) begin
        $error("divide_fault: expected %0b, got %0b", e.fault, fault);
        errors++;
      end
      if (sat !== e.sat) begin
        $error("saturated: expected %0b, got %0b", e.sat, sat);
        errors++;
      end
    endfunction
  endclass

  logic                       clk;
  logic                       rst_n;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [vtp_pkg::ADDR_W-1:0] paddr;
  logic [31:0]                pwdata;
  logic [31:0]                prdata;
  logic                       pready;

  vtp_in_if  in_ch ();
  vtp_out_if out_ch ();

  vertex_transform_project_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  projection_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Run limit.
  initial begin
    #4000000;
    $display("vertex_transform_project_core: mismatch");
    $finish;
  end

  // Receiver stalls.
  always @(negedge clk) begin
    out_ch.ready = ($urandom_range(99) >= recv_idle_pct);
  end

  // Observe both handshakes at the rising edge.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_word(vtp_pkg::cmd_t'(in_ch.command), in_ch.matrix_select,
                   in_ch.element_index, in_ch.element_value, in_ch.vertex_x,
                   in_ch.vertex_y, in_ch.vertex_z);
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.screen_x, out_ch.screen_y, out_ch.depth,
                      out_ch.divide_fault, out_ch.saturated);
  end

  // Send one word, after idle cycles drawn at the sender's idle rate.
  // Called at a falling edge.
  task automatic send_word(vtp_pkg::cmd_t cmd, logic [1:0] sel, logic [3:0] idx,
                           logic [31:0] val, logic [31:0] x, logic [31:0] y,
                           logic [31:0] z);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid = 1'b1;
    in_ch.command = cmd;
    in_ch.matrix_select = sel;
    in_ch.element_index = idx;
    in_ch.element_value = val;
    in_ch.vertex_x = x;
    in_ch.vertex_y = y;
    in_ch.vertex_z = z;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic write_coef(logic [1:0] sel, logic [3:0] idx, logic [31:0] val);
    send_word(vtp_pkg::CMD_WRITE, sel, idx, val, $urandom, $urandom, $urandom);
  endtask

  task automatic project(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    send_word(vtp_pkg::CMD_XFORM, 2'($urandom), 4'($urandom), $urandom, x, y, z);
  endtask

  // Register write: setup cycle, then access cycle.
  task automatic write_focal(logic [31:0] val);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = vtp_pkg::REG_FOCAL_ADDR;
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.focal = val;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Wait until every predicted result has come, then let the pipeline empty.
  task automatic drain();
    in_ch.valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Random Q16.16 value: mostly small, sometimes full range, an extreme, one or zero.
  function automatic logic [31:0] rand_fixed();
    int unsigned c;
    c = $urandom_range(99);
    if (c < 70) return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
    if (c < 80) return $urandom;
    if (c < 85) return 32'h8000_0000;
    if (c < 90) return 32'h7fff_ffff;
    if (c < 95) return 32'h0001_0000;
    return 32'h0;
  endfunction

  // Near-identity matrix with small random terms.
  task automatic load_matrix(logic [1:0] sel);
    logic [31:0] val;
    for (int i = 0; i < 16; i++) begin
      val = $signed($urandom_range(0, 1 << 16)) - (1 << 15);
      if (i % 5 == 0) val = val + 32'h0001_0000;
      write_coef(sel, i[3:0], val);
    end
  endtask

  // Random phase: coefficient updates followed by bursts of vertices.
  task automatic random_phase(int words);
    int sent;
    sent = 0;
    while (sent < words) begin
      if ($urandom_range(19) == 0) begin
        load_matrix(2'($urandom_range(2)));
        sent += 16;
      end
      repeat ($urandom_range(0, 3)) begin
        write_coef($urandom_range(9) == 0 ? vtp_pkg::MSEL_UNUSED : 2'($urandom_range(2)),
                   4'($urandom), rand_fixed());
        sent++;
      end
      repeat ($urandom_range(1, 8)) begin
        project(rand_fixed(), rand_fixed(), rand_fixed());
        sent++;
      end
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.command = vtp_pkg::CMD_WRITE;
    in_ch.matrix_select = '0;
    in_ch.element_index = '0;
    in_ch.element_value = '0;
    in_ch.vertex_x = '0;
    in_ch.vertex_y = '0;
    in_ch.vertex_z = '0;
    out_ch.ready = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: all matrices zero, so every divisor is zero.
    project(32'h0001_0000, 32'h8000_0000, 32'h7fff_ffff);
    // An unused select leaves the store alone.
    write_coef(vtp_pkg::MSEL_UNUSED, 4'd15, 32'h7fff_ffff);
    project(32'h0, 32'h0, 32'h0);
    // Identity model and view, camera with w taken from -z.
    for (int i = 0; i < 16; i += 5) begin
      write_coef(vtp_pkg::MSEL_MODEL, i[3:0], 32'h0001_0000);
      write_coef(vtp_pkg::MSEL_VIEW, i[3:0], 32'h0001_0000);
    end
    write_coef(vtp_pkg::MSEL_CAMERA, 4'd0, 32'h0001_0000);
    write_coef(vtp_pkg::MSEL_CAMERA, 4'd5, 32'h0001_0000);
    write_coef(vtp_pkg::MSEL_CAMERA, 4'd10, 32'h0001_0000);
    write_coef(vtp_pkg::MSEL_CAMERA, 4'd11, 32'hffff_0000);
    project(32'h0002_0000, 32'hfffd_0000, 32'hfffc_0000);
    project(32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000);
    project(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    project(32'h0005_0000, 32'h0003_0000, 32'h0);
    project(32'hffff_ffff, 32'h0000_0001, 32'h7fff_ffff);
    drain();

    // Focal length set to its extremes, a small random value and zero, one setting per phase.
    write_focal(32'h8000_0000);
    send_idle_pct = 25;
    recv_idle_pct = 50;
    random_phase(650);
    drain();

    write_focal(32'h7fff_ffff);
    send_idle_pct = 50;
    recv_idle_pct = 25;
    random_phase(650);
    drain();

    write_focal($signed($urandom_range(0, 1 << 19)) - (1 << 18));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(600);
    drain();

    write_focal(32'h0);
    random_phase(120);
    drain();

    if (sb.errors == 0) begin
      $display("vertex_transform_project_core: match");
    end else begin
      $display("vertex_transform_project_core: mismatch");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/vtp_pkg.sv
sv/vtp_in_if.sv
sv/vtp_out_if.sv
sv/vtp_queue.sv
sv/vtp_vecmat.sv
sv/vtp_divide.sv
sv/vertex_transform_project_core.sv
tb/tb_vertex_transform_project_core.sv
